### src/bmce_pkg.sv
`default_nettype none
package bmce_pkg;
  localparam int unsigned MemDepth  = 65536;
  localparam int unsigned AddrW     = $clog2(MemDepth);
  localparam int unsigned MaxRun    = 64;
  localparam int unsigned SizeLimit = 4000000;

  typedef enum logic [2:0] {
    REQ_SIZE    = 3'd0,
    REQ_WRITE   = 3'd1,
    REQ_FILL    = 3'd2,
    REQ_COPY    = 3'd3,
    REQ_COMPARE = 3'd4,
    REQ_READ    = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    RES_DONE     = 2'd0,
    RES_MISMATCH = 2'd1,
    RES_READ     = 2'd2,
    RES_RANGE    = 2'd3
  } res_e;
endpackage
`default_nettype wire

### src/bmce_mem.sv
`default_nettype none
module bmce_mem
  import bmce_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [7:0]       wdata_i,
  output logic      [7:0]       rdata_o
);
  logic [7:0] mem [MemDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule
`default_nettype wire

### src/byte_memory_command_engine_core.sv
// Byte memory command engine.
// Input channel: one command item per handshake (req_type, addresses, data
// byte, run length, new size), accepted while in_valid_i is high and
// in_stall_o is low. The engine takes one command at a time and holds
// in_stall_o high until its last result is loaded into the output register.
// Output channel: result items held in an output register until accepted
// (out_valid_o high, out_stall_i low); while the receiver stalls, the item
// holds and the engine waits.
// The engine works on a single-port byte memory with a registered read,
// and any output stall holds the command in progress.
// The size command clears one byte per cycle.
// A range error or empty run gives one result.
// Reset sets the active size to zero and empties the output register; the
// memory content is undefined until a size command clears it.
// Request codes 6 and 7 are dropped without a result.
`default_nettype none
module byte_memory_command_engine_core
  import bmce_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  req_type_i,
  input  wire logic [15:0] addr_a_i,
  input  wire logic [15:0] addr_b_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [6:0]  run_length_i,
  input  wire logic [16:0] new_size_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [15:0]      first_address_o,
  output logic [15:0]      second_address_o,
  output logic [7:0]       first_value_o,
  output logic [7:0]       second_value_o,
  output logic             last_o
);
  typedef enum logic [2:0] {
    ST_IDLE, ST_CLR, ST_RA, ST_RB, ST_CMP, ST_FIN, ST_PUT
  } state_e;

  state_e      state_q, ret_q;
  logic [2:0]  type_q;
  logic [15:0] a_q, b_q;
  logic [7:0]  val_q;
  logic [6:0]  len_q, idx_q;
  logic [16:0] size_q;
  logic [AddrW-1:0] clr_q;
  logic [7:0]  x_q;
  logic        pend_q;
  logic [15:0] pa_q, pb_q;
  logic [7:0]  px_q, py_q;
  logic [1:0]  rk_q;
  logic [15:0] ra_q, rb_q;
  logic [7:0]  rx_q, ry_q;
  logic        rl_q;

  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic             in_acc, slot_free, at_end, put_go;
  logic [15:0]      ai, bi;
  logic [17:0]      end_a, end_b;
  logic             bad_run;

  bmce_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_o || !out_stall_i;
  assign put_go     = (state_q == ST_PUT) && slot_free;
  assign ai         = a_q + {9'd0, idx_q};
  assign bi         = b_q + {9'd0, idx_q};
  assign at_end     = (idx_q == len_q - 7'd1);
  assign end_a      = {2'b00, addr_a_i} + {11'd0, run_length_i};
  assign end_b      = {2'b00, addr_b_i} + {11'd0, run_length_i};
  assign bad_run    = ({25'd0, run_length_i} > MaxRun) || (end_a > {1'b0, size_q}) ||
                      (((req_type_i == REQ_COPY) || (req_type_i == REQ_COMPARE)) &&
                       (end_b > {1'b0, size_q}));

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = ai[AddrW-1:0];
    mem_wdata = val_q;
    unique case (state_q)
      ST_IDLE: begin
        mem_addr  = addr_a_i[AddrW-1:0];
        mem_wdata = data_byte_i;
        mem_we    = in_acc && (req_type_i == REQ_WRITE) &&
                    ({1'b0, addr_a_i} < size_q);
      end
      ST_CLR: begin
        mem_addr  = clr_q;
        mem_wdata = 8'd0;
        mem_we    = 1'b1;
      end
      ST_RA: mem_we = (type_q == REQ_FILL);
      ST_RB: begin
        mem_addr  = bi[AddrW-1:0];
        mem_wdata = mem_rdata;
        mem_we    = (type_q == REQ_COPY);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      size_q      <= '0;
      pend_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (put_go) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            type_q <= req_type_i;
            a_q    <= addr_a_i;
            b_q    <= addr_b_i;
            val_q  <= data_byte_i;
            len_q  <= run_length_i;
            idx_q  <= '0;
            clr_q  <= '0;
            pend_q <= 1'b0;
            rk_q   <= RES_DONE;
            ra_q   <= '0;
            rb_q   <= '0;
            rx_q   <= '0;
            ry_q   <= '0;
            rl_q   <= 1'b1;
            ret_q  <= ST_IDLE;
            priority if (req_type_i > REQ_READ) begin
              state_q <= ST_IDLE;
            end else if (req_type_i == REQ_SIZE) begin
              if ({15'd0, new_size_i} > MemDepth || {15'd0, new_size_i} > SizeLimit) begin
                rk_q    <= RES_RANGE;
                ra_q    <= addr_a_i;
                state_q <= ST_PUT;
              end else begin
                size_q  <= new_size_i;
                state_q <= (new_size_i == 17'd0) ? ST_PUT : ST_CLR;
              end
            end else if (req_type_i == REQ_WRITE) begin
              if ({1'b0, addr_a_i} >= size_q) begin
                rk_q <= RES_RANGE;
                ra_q <= addr_a_i;
              end
              state_q <= ST_PUT;
            end else if (bad_run) begin
              rk_q    <= RES_RANGE;
              ra_q    <= addr_a_i;
              state_q <= ST_PUT;
            end else if (run_length_i == 7'd0) begin
              state_q <= ST_PUT;
            end else begin
              state_q <= ST_RA;
            end
          end
        end
        ST_CLR: begin
          clr_q <= clr_q + AddrW'(1);
          if ({1'b0, clr_q} == size_q - 17'd1) begin
            state_q <= ST_FIN;
          end
        end
        ST_RA: begin
          if (type_q == REQ_FILL) begin
            idx_q   <= idx_q + 7'd1;
            state_q <= at_end ? ST_FIN : ST_RA;
          end else begin
            state_q <= ST_RB;
          end
        end
        ST_RB: begin
          unique case (type_q)
            REQ_COPY: begin
              idx_q   <= idx_q + 7'd1;
              state_q <= at_end ? ST_FIN : ST_RA;
            end
            REQ_READ: begin
              rk_q    <= RES_READ;
              ra_q    <= ai;
              rb_q    <= '0;
              rx_q    <= mem_rdata;
              ry_q    <= '0;
              rl_q    <= at_end;
              ret_q   <= at_end ? ST_IDLE : ST_RA;
              idx_q   <= idx_q + 7'd1;
              state_q <= ST_PUT;
            end
            default: begin
              x_q     <= mem_rdata;
              state_q <= ST_CMP;
            end
          endcase
        end
        ST_CMP: begin
          idx_q <= idx_q + 7'd1;
          if (x_q != mem_rdata) begin
            pend_q <= 1'b1;
            pa_q   <= ai;
            pb_q   <= bi;
            px_q   <= x_q;
            py_q   <= mem_rdata;
          end
          if (x_q != mem_rdata && pend_q) begin
            rk_q    <= RES_MISMATCH;
            ra_q    <= pa_q;
            rb_q    <= pb_q;
            rx_q    <= px_q;
            ry_q    <= py_q;
            rl_q    <= 1'b0;
            ret_q   <= at_end ? ST_FIN : ST_RA;
            state_q <= ST_PUT;
          end else begin
            state_q <= at_end ? ST_FIN : ST_RA;
          end
        end
        ST_FIN: begin
          if (pend_q) begin
            rk_q <= RES_MISMATCH;
            ra_q <= pa_q;
            rb_q <= pb_q;
            rx_q <= px_q;
            ry_q <= py_q;
          end else begin
            rk_q <= RES_DONE;
            ra_q <= '0;
            rb_q <= '0;
            rx_q <= '0;
            ry_q <= '0;
          end
          rl_q    <= 1'b1;
          pend_q  <= 1'b0;
          ret_q   <= ST_IDLE;
          state_q <= ST_PUT;
        end
        ST_PUT: begin
          if (slot_free) begin
            result_kind_o    <= rk_q;
            first_address_o  <= ra_q;
            second_address_o <= rb_q;
            first_value_o    <= rx_q;
            second_value_o   <= ry_q;
            last_o           <= rl_q;
            state_q          <= ret_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
